// ----- rtl/cfid_pkg.sv -----
// shared types and constants for the cascaded fir interpolator / decimator
// no dependencies; imported by the interfaces, cfid_decim and the top level
package cfid_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TAPS_W     = 7;
	localparam int UP_W       = 3;
	localparam int DEC_W      = 16;
	localparam int ACC_W      = 32;
	localparam int SAMPLE_W   = 16;
	localparam int Q_SHIFT    = 16;
	localparam int SEL_W      = 2;
	localparam int CIDX_W     = 5;

	localparam logic [CFG_IDX_W-1:0] REG_TAPS_FIRST      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAPS_SECOND     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAPS_THIRD      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UPSAMPLE_FIRST  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UPSAMPLE_SECOND = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UPSAMPLE_THIRD  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DECIMATION      = 3'd6;

	localparam logic [UP_W-1:0] MAX_REPEAT = 3'd4;

	localparam logic MODE_AUDIO = 1'b0;
	localparam logic MODE_COEF  = 1'b1;

	localparam logic [SEL_W-1:0] STAGE_FIRST  = 2'd0;
	localparam logic [SEL_W-1:0] STAGE_SECOND = 2'd1;
	localparam logic [SEL_W-1:0] STAGE_THIRD  = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_SCAT,
		ST_NEXT_A,
		ST_NEXT_B,
		ST_NEXT_C,
		ST_POP,
		ST_FLUSH
	} cfid_state_t;

	typedef enum logic [1:0] {
		SIDE_RIGHT,
		SIDE_LEFT,
		SIDE_CENTRE
	} cfid_side_t;

	typedef struct packed {
		logic start;
		logic tick;
	} decim_ctl_t;

	typedef struct packed {
		logic busy;
		logic emit;
	} decim_sts_t;

endpackage

// ----- rtl/cfid_if.sv -----
// valid/ready channel interfaces for input items and result items
// depends on cfid_pkg
interface cfid_item_if;
	import cfid_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [SEL_W-1:0]           table_select;
	logic [CIDX_W-1:0]          coef_index;
	logic signed [ACC_W-1:0]    coef_value;
	logic signed [SAMPLE_W-1:0] audio_in;

	modport source (output valid, mode, table_select, coef_index, coef_value, audio_in,
		input ready);
	modport sink (input valid, mode, table_select, coef_index, coef_value, audio_in,
		output ready);
endinterface

interface cfid_result_if;
	import cfid_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] audio_out;
	logic                       last;

	modport source (output valid, audio_out, last, input ready);
	modport sink (input valid, audio_out, last, output ready);
endinterface

// ----- rtl/cascaded_fir_interp_decimator_unit.sv -----
// top level of the three-stage symmetric fir interpolator / decimator
// depends on cfid_pkg, cfid_if (item and result channels) and cfid_decim
//
// An audio sample first rebuilds the decimation residue, then does each ring
// accumulate (scatter term: read, multiply, write back) and each pop or output tick
// (read, then clear), all through the one read and one write port of the ring
// memory. The next item is taken once the last result has moved into the output
// register. After reset a clearing pass zeroes the rings and coefficient tables;
// no item is taken during it, configuration writes are.
module cascaded_fir_interp_decimator_unit #(
	parameter int MAX_TAPS   = 64,
	parameter int COEF_DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cfid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cfid_pkg::CFG_DATA_W-1:0] cfg_data,
	cfid_item_if.sink                       item,
	cfid_result_if.source                   result
);
	import cfid_pkg::*;

	localparam int AW         = $clog2(MAX_TAPS);
	localparam int LW         = $clog2(MAX_TAPS + 1);
	localparam int CW         = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
	localparam int RING_WORDS = 3 * (2 ** AW);
	localparam int COEF_WORDS = 3 * (2 ** CW);
	localparam int CLR_WORDS  = (RING_WORDS > COEF_WORDS) ? RING_WORDS : COEF_WORDS;
	localparam int CLW        = ((AW > CW) ? AW : CW) + 2;
	localparam logic [CLW-1:0] CLR_LAST = CLW'(CLR_WORDS - 1);

	// configuration
	logic [TAPS_W-1:0] taps_q [0:2];
	logic [UP_W-1:0]   up_q   [0:2];
	logic [DEC_W-1:0]  dec_q;

	logic [LW-1:0]     len_k  [0:2];
	logic [UP_W-1:0]   rep_k  [0:2];
	logic [DEC_W-1:0]  dec_eff;

	// sequencer state
	cfid_state_t       state_q, state_d;
	logic [1:0]        ph_q;
	logic [SEL_W-1:0]  stg_q;
	cfid_side_t        side_q;
	logic [LW-1:0]     i_q;
	logic [UP_W-1:0]   a_q, b_q, c_q;
	logic [AW-1:0]     h_q [0:2];
	logic [CLW-1:0]    clr_q;

	// datapath
	logic [ACC_W-1:0]  x_q;
	logic [ACC_W-1:0]  prod_q;
	logic [AW-1:0]     addr_q;
	logic              czero_q;
	logic              hold_vld_q;
	logic [SAMPLE_W-1:0] hold_q;
	logic              out_vld_q;
	logic [SAMPLE_W-1:0] out_data_q;
	logic              out_last_q;

	// memories
	logic [ACC_W-1:0]  ring_mem [0:RING_WORDS-1];
	logic [ACC_W-1:0]  coef_mem [0:COEF_WORDS-1];
	logic [ACC_W-1:0]  ring_rd_q;
	logic [ACC_W-1:0]  coef_rd_q;

	logic              ring_re, ring_we;
	logic [AW+1:0]     ring_ra, ring_wa;
	logic [ACC_W-1:0]  ring_wd;
	logic              coef_re, coef_we;
	logic [CW+1:0]     coef_ra, coef_wa;
	logic [ACC_W-1:0]  coef_wd;

	// current stage view
	logic [LW-1:0]     cur_len, cur_pairs, off, cidx;
	logic              cur_centre;
	logic [AW-1:0]     cur_h, slot, head_next, op_addr;
	logic [LW:0]       cur_h_w, sum_w, wrap_w, hnx_w;
	logic [ACC_W-1:0]  mul_lo, term;

	logic accept, is_audio, is_coef, out_free, clearing;
	logic scat_skip, scat_end, scat_issue, scat_mul, scat_wr;
	logic pop_issue, pop_stall, pop_done, emit_now, flush_push, push;
	logic go_a, go_b, go_c;

	decim_ctl_t dctl;
	decim_sts_t dsts;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (taps_q[k] == '0) begin
				len_k[k] = LW'(1);
			end else if (32'(taps_q[k]) > 32'(MAX_TAPS)) begin
				len_k[k] = LW'(MAX_TAPS);
			end else begin
				len_k[k] = LW'(taps_q[k]);
			end
			rep_k[k] = (up_q[k] > MAX_REPEAT) ? MAX_REPEAT : up_q[k];
		end
		dec_eff = (dec_q == '0) ? DEC_W'(1) : dec_q;
	end

	always_comb begin
		cur_len = len_k[stg_q];
		cur_h   = h_q[stg_q];
		case (stg_q)
			STAGE_FIRST: begin
				cur_pairs  = cur_len >> 1;
				cur_centre = cur_len[0];
			end
			STAGE_SECOND: begin
				cur_pairs  = cur_len >> 1;
				cur_centre = 1'b0;
			end
			default: begin
				cur_pairs  = (cur_len - LW'(1)) >> 1;
				cur_centre = 1'b1;
			end
		endcase
		case (side_q)
			SIDE_LEFT:   off = cur_len - LW'(1) - i_q;
			SIDE_CENTRE: off = cur_pairs;
			default:     off = i_q;
		endcase
		cidx    = (side_q == SIDE_CENTRE) ? cur_pairs : i_q;
		cur_h_w = (LW+1)'(cur_h);
		sum_w   = cur_h_w + (LW+1)'(off);
		wrap_w  = (sum_w >= (LW+1)'(cur_len)) ? sum_w - (LW+1)'(cur_len) : sum_w;
		slot    = AW'(wrap_w);
		hnx_w   = cur_h_w + (LW+1)'(1);
		head_next = (hnx_w == (LW+1)'(cur_len)) ? '0 : AW'(hnx_w);
		op_addr = (state_q == ST_POP) ? cur_h : slot;
	end

	assign mul_lo = coef_rd_q * x_q;
	assign term   = $signed(prod_q) >>> Q_SHIFT;

	// control strobes
	always_comb begin
		clearing   = (state_q == ST_CLEAR);
		accept     = item.valid && item.ready;
		is_audio   = accept && (item.mode == MODE_AUDIO);
		is_coef    = accept && (item.mode == MODE_COEF);
		out_free   = !out_vld_q || result.ready;
		scat_skip  = (state_q == ST_SCAT) && (ph_q == 2'd0) && (side_q != SIDE_CENTRE)
			&& (i_q >= cur_pairs);
		scat_end   = (state_q == ST_SCAT) && (ph_q == 2'd0) && (side_q == SIDE_CENTRE)
			&& !cur_centre;
		scat_issue = (state_q == ST_SCAT) && (ph_q == 2'd0) && !scat_skip && !scat_end;
		scat_mul   = (state_q == ST_SCAT) && (ph_q == 2'd1);
		scat_wr    = (state_q == ST_SCAT) && (ph_q == 2'd2);
		pop_issue  = (state_q == ST_POP) && (ph_q == 2'd0);
		// a new result needs the held one moved out first
		pop_stall  = (state_q == ST_POP) && (ph_q == 2'd1) && (stg_q == STAGE_THIRD)
			&& dsts.emit && hold_vld_q && !out_free;
		pop_done   = (state_q == ST_POP) && (ph_q == 2'd1) && !pop_stall;
		emit_now   = pop_done && (stg_q == STAGE_THIRD) && dsts.emit;
		flush_push = (state_q == ST_FLUSH) && hold_vld_q && out_free;
		push       = (emit_now && hold_vld_q) || flush_push;
		go_a       = (state_q == ST_NEXT_A) && (a_q < rep_k[0]);
		go_b       = (state_q == ST_NEXT_B) && (b_q < rep_k[1]);
		go_c       = (state_q == ST_NEXT_C) && (c_q < rep_k[2]);

		ring_re = scat_issue || pop_issue;
		ring_ra = {stg_q, op_addr};
		ring_we = (clearing && (32'(clr_q) < 32'(RING_WORDS))) || scat_wr || pop_done;
		if (clearing) begin
			ring_wa = clr_q[AW+1:0];
			ring_wd = '0;
		end else begin
			ring_wa = {stg_q, addr_q};
			ring_wd = scat_wr ? ring_rd_q + term : '0;
		end

		coef_re = scat_issue;
		coef_ra = {stg_q, CW'(cidx)};
		coef_we = (clearing && (32'(clr_q) < 32'(COEF_WORDS)))
			|| (is_coef && (item.table_select <= STAGE_THIRD)
			&& (32'(item.coef_index) < 32'(COEF_DEPTH)));
		if (clearing) begin
			coef_wa = clr_q[CW+1:0];
			coef_wd = '0;
		end else begin
			coef_wa = {item.table_select, CW'(item.coef_index)};
			coef_wd = item.coef_value;
		end

		dctl.start = is_audio;
		dctl.tick  = pop_done && (stg_q == STAGE_THIRD);
	end

	// next state
	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item.ready = 1'b1;
				if (is_audio) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (!dsts.busy) begin
					state_d = ST_SCAT;
				end
			end
			ST_SCAT: begin
				if (scat_end || (scat_wr && (side_q == SIDE_CENTRE))) begin
					case (stg_q)
						STAGE_FIRST:  state_d = ST_NEXT_A;
						STAGE_SECOND: state_d = ST_NEXT_B;
						default:      state_d = ST_NEXT_C;
					endcase
				end
			end
			ST_NEXT_A: state_d = go_a ? ST_POP : ST_FLUSH;
			ST_NEXT_B: state_d = go_b ? ST_POP : ST_NEXT_A;
			ST_NEXT_C: state_d = go_c ? ST_POP : ST_NEXT_B;
			ST_POP: begin
				if (pop_done) begin
					state_d = (stg_q == STAGE_THIRD) ? ST_NEXT_C : ST_SCAT;
				end
			end
			ST_FLUSH: begin
				if (!hold_vld_q || flush_push) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				taps_q[k] <= TAPS_W'(1);
				up_q[k]   <= UP_W'(1);
			end
			dec_q <= DEC_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAPS_FIRST:      taps_q[0] <= cfg_data[TAPS_W-1:0];
				REG_TAPS_SECOND:     taps_q[1] <= cfg_data[TAPS_W-1:0];
				REG_TAPS_THIRD:      taps_q[2] <= cfg_data[TAPS_W-1:0];
				REG_UPSAMPLE_FIRST:  up_q[0]   <= cfg_data[UP_W-1:0];
				REG_UPSAMPLE_SECOND: up_q[1]   <= cfg_data[UP_W-1:0];
				REG_UPSAMPLE_THIRD:  up_q[2]   <= cfg_data[UP_W-1:0];
				REG_DECIMATION:      dec_q     <= cfg_data[DEC_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer counters, heads and result staging
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q       <= '0;
			stg_q      <= STAGE_FIRST;
			side_q     <= SIDE_RIGHT;
			i_q        <= '0;
			a_q        <= '0;
			b_q        <= '0;
			c_q        <= '0;
			clr_q      <= '0;
			hold_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				h_q[k] <= '0;
			end
		end else begin
			if (clearing) begin
				clr_q <= clr_q + CLW'(1);
			end
			if (is_audio) begin
				a_q <= '0;
				for (int k = 0; k < 3; k++) begin
					if (LW'(h_q[k]) >= len_k[k]) begin
						h_q[k] <= '0;
					end
				end
			end
			if ((state_q == ST_MOD) && !dsts.busy) begin
				stg_q  <= STAGE_FIRST;
				i_q    <= '0;
				side_q <= SIDE_RIGHT;
				ph_q   <= '0;
			end
			if (scat_skip) begin
				side_q <= SIDE_CENTRE;
			end
			if (scat_issue || scat_mul) begin
				ph_q <= ph_q + 2'd1;
			end
			if (scat_wr) begin
				ph_q <= '0;
				if (side_q == SIDE_RIGHT) begin
					side_q <= SIDE_LEFT;
				end else if (side_q == SIDE_LEFT) begin
					side_q <= SIDE_RIGHT;
					i_q    <= i_q + LW'(1);
				end
			end
			if (go_a) begin
				a_q   <= a_q + UP_W'(1);
				stg_q <= STAGE_FIRST;
				ph_q  <= '0;
			end
			if (go_b) begin
				b_q   <= b_q + UP_W'(1);
				stg_q <= STAGE_SECOND;
				ph_q  <= '0;
			end
			if (go_c) begin
				c_q   <= c_q + UP_W'(1);
				stg_q <= STAGE_THIRD;
				ph_q  <= '0;
			end
			if (pop_issue) begin
				ph_q <= 2'd1;
			end
			if (pop_done) begin
				ph_q       <= '0;
				h_q[stg_q] <= head_next;
				if (stg_q != STAGE_THIRD) begin
					// the popped sum feeds the next stage scatter
					stg_q  <= stg_q + SEL_W'(1);
					i_q    <= '0;
					side_q <= SIDE_RIGHT;
				end
				if (stg_q == STAGE_FIRST) begin
					b_q <= '0;
				end
				if (stg_q == STAGE_SECOND) begin
					c_q <= '0;
				end
			end
			if (emit_now) begin
				hold_vld_q <= 1'b1;
			end else if (flush_push) begin
				hold_vld_q <= 1'b0;
			end
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (is_audio) begin
			x_q <= {{(ACC_W-SAMPLE_W){item.audio_in[SAMPLE_W-1]}}, item.audio_in};
		end else if (pop_done && (stg_q != STAGE_THIRD)) begin
			x_q <= ring_rd_q;
		end
		if (scat_issue || pop_issue) begin
			addr_q <= op_addr;
		end
		if (scat_issue) begin
			czero_q <= (32'(cidx) >= 32'(COEF_DEPTH));
		end
		if (scat_mul) begin
			prod_q <= czero_q ? '0 : mul_lo;
		end
		if (emit_now) begin
			hold_q <= ring_rd_q[SAMPLE_W-1:0];
		end
		if (push) begin
			out_data_q <= hold_q;
			out_last_q <= flush_push;
		end
	end

	// ring accumulator memory, one read and one write port
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_wa] <= ring_wd;
		end
		if (ring_re) begin
			ring_rd_q <= ring_mem[ring_ra];
		end
	end

	// coefficient tables, one read and one write port
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_wa] <= coef_wd;
		end
		if (coef_re) begin
			coef_rd_q <= coef_mem[coef_ra];
		end
	end

	cfid_decim u_decim (
		.clk    (clk),
		.arst_n (arst_n),
		.dec    (dec_eff),
		.ctl    (dctl),
		.sts    (dsts)
	);

	assign result.valid     = out_vld_q;
	assign result.audio_out = out_data_q;
	assign result.last      = out_last_q;

	// a held result never outlives its item
	a_hold_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !hold_vld_q)
		else $error("held result left behind at idle");

	// output ticks only once the residue is rebuilt
	a_tick_ready: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.tick |-> !dsts.busy)
		else $error("tick during residue rebuild");

	// ring heads stay inside the ring in use
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAT || state_q == ST_POP) |-> cur_h_w < (LW+1)'(cur_len))
		else $error("ring head beyond length");

	// a transfer into the output register never overwrites a pending result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("result overwritten");

endmodule

// ----- rtl/cfid_decim.sv -----
// output tick phase counter with decimation test
// depends on cfid_pkg; holds the phase residue, rebuilt by a bit-serial remainder unit
module cfid_decim (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [cfid_pkg::DEC_W-1:0] dec,
	input  cfid_pkg::decim_ctl_t    ctl,
	output cfid_pkg::decim_sts_t    sts
);
	import cfid_pkg::*;

	logic [DEC_W-1:0] phase_q;
	logic [DEC_W-1:0] res_q;
	logic [3:0]       bit_q;
	logic             busy_q;

	logic [DEC_W:0]   trial;
	logic [DEC_W-1:0] res_step;
	logic             emit;
	logic [DEC_W-1:0] phase_d;
	logic [DEC_W-1:0] res_base;
	logic [DEC_W:0]   res_inc;
	logic [DEC_W-1:0] res_tick;

	always_comb begin
		// one restoring remainder step, msb first
		trial = {res_q, phase_q[bit_q]};
		if (trial >= {1'b0, dec}) begin
			res_step = DEC_W'(trial - {1'b0, dec});
		end else begin
			res_step = trial[DEC_W-1:0];
		end
		emit     = (res_q == '0);
		phase_d  = (emit ? '0 : phase_q) + DEC_W'(1);
		res_base = emit ? '0 : res_q;
		res_inc  = {1'b0, res_base} + (DEC_W+1)'(1);
		// phase wraps to zero, so the residue does too
		if (phase_d == '0) begin
			res_tick = '0;
		end else if (res_inc == {1'b0, dec}) begin
			res_tick = '0;
		end else begin
			res_tick = res_inc[DEC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			res_q   <= '0;
			bit_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			if (ctl.start) begin
				res_q  <= '0;
				bit_q  <= 4'd15;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				res_q <= res_step;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					bit_q <= bit_q - 4'd1;
				end
			end else if (ctl.tick) begin
				phase_q <= phase_d;
				res_q   <= res_tick;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.emit = emit;

endmodule

// ----- tb/sv/cascaded_fir_interp_decimator_unit_tb.sv -----
// testbench for cascaded_fir_interp_decimator_unit: directed and random audio and
// coefficient traffic checked against a built-in three-stage resampler predictor
// depends on cfid_pkg, cfid_if and the rtl top level
`timescale 1ns / 1ps

module cascaded_fir_interp_decimator_unit_tb;
	import cfid_pkg::*;

	localparam int RING_DEPTH = 64;
	localparam int TABLE_DEPTH = 32;
	localparam int SETTLE_CYCLES = 5000;
	localparam int STALL_LIMIT = 60000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [SEL_W-1:0] STAGE_NONE = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] audio_out;
		logic                       last;
	} pcm_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cfid_item_if item_ch();
	cfid_result_if result_ch();

	cascaded_fir_interp_decimator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item_ch),
		.result(result_ch)
	);

	// predictor state
	logic [ACC_W-1:0] acc_ring[3][RING_DEPTH];
	logic [ACC_W-1:0] coef_tab[3][TABLE_DEPTH];
	int unsigned ring_head[3];
	logic [DEC_W-1:0] tick_count;
	logic [TAPS_W-1:0] taps_reg[3];
	logic [UP_W-1:0] repeat_reg[3];
	logic [DEC_W-1:0] decim_reg;

	pcm_result_t pending_pcm[$];
	int errors = 0;
	int items_sent = 0;
	int pcm_checked = 0;
	int hold_request = 0;
	bit steady_sink = 0;
	bit steady_source = 0;
	int quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [ACC_W-1:0] q16_mul(logic [ACC_W-1:0] c, logic [ACC_W-1:0] x);
		logic [ACC_W-1:0] low;
		low = c * x;
		return $signed(low) >>> Q_SHIFT;
	endfunction

	function automatic int unsigned wrap_idx(int unsigned v, int unsigned len);
		return (v >= len) ? v - len : v;
	endfunction

	function automatic int unsigned ring_len(logic [TAPS_W-1:0] t);
		if (t == 0) return 1;
		if (t > RING_DEPTH) return RING_DEPTH;
		return t;
	endfunction

	function automatic logic [ACC_W-1:0] coef_read(int s, int unsigned i);
		return (i < TABLE_DEPTH) ? coef_tab[s][i] : '0;
	endfunction

	// mirrored scatter around the head, optional centre tap after the pairs
	task automatic spread(input int s, input logic [ACC_W-1:0] x, input int unsigned pairs,
			input int unsigned len, input bit with_centre);
		int unsigned h;
		logic [ACC_W-1:0] term;
		h = ring_head[s];
		for (int unsigned i = 0; i < pairs; i++) begin
			term = q16_mul(coef_read(s, i), x);
			acc_ring[s][wrap_idx(h + i, len)] += term;
			acc_ring[s][wrap_idx(h + len - 1 - i, len)] += term;
		end
		if (with_centre)
			acc_ring[s][wrap_idx(h + pairs, len)] += q16_mul(coef_read(s, pairs), x);
	endtask

	task automatic predict_audio(input logic signed [SAMPLE_W-1:0] sample);
		int unsigned len[3];
		int unsigned rep[3];
		int unsigned dec;
		int n;
		logic [ACC_W-1:0] s1, s2;
		pcm_result_t r;
		n = 0;
		for (int k = 0; k < 3; k++) begin
			len[k] = ring_len(taps_reg[k]);
			rep[k] = (repeat_reg[k] > MAX_REPEAT) ? MAX_REPEAT : repeat_reg[k];
			if (ring_head[k] >= len[k]) ring_head[k] = 0;
		end
		dec = (decim_reg == 0) ? 1 : decim_reg;
		spread(0, ACC_W'(sample), len[0] / 2, len[0], len[0][0]);
		for (int unsigned a = 0; a < rep[0]; a++) begin
			s1 = acc_ring[0][ring_head[0]];
			spread(1, s1, len[1] / 2, len[1], 1'b0);
			for (int unsigned b = 0; b < rep[1]; b++) begin
				s2 = acc_ring[1][ring_head[1]];
				spread(2, s2, (len[2] - 1) / 2, len[2], 1'b1);
				for (int unsigned c = 0; c < rep[2]; c++) begin
					if (tick_count % dec == 0) begin
						r.audio_out = acc_ring[2][ring_head[2]][SAMPLE_W-1:0];
						r.last = 1'b0;
						pending_pcm.push_back(r);
						n++;
						tick_count = 0;
					end
					acc_ring[2][ring_head[2]] = '0;
					ring_head[2] = wrap_idx(ring_head[2] + 1, len[2]);
					tick_count = tick_count + 1'b1;
				end
				acc_ring[1][ring_head[1]] = '0;
				ring_head[1] = wrap_idx(ring_head[1] + 1, len[1]);
			end
			acc_ring[0][ring_head[0]] = '0;
			ring_head[0] = wrap_idx(ring_head[0] + 1, len[0]);
		end
		if (n > 0) pending_pcm[$].last = 1'b1;
	endtask

	// one transfer on the item channel, then a random gap unless the source is held steady
	task automatic send_item(input logic mode, input logic [SEL_W-1:0] sel,
			input logic [CIDX_W-1:0] idx, input logic [ACC_W-1:0] coef,
			input logic [SAMPLE_W-1:0] sample);
		int gap;
		item_ch.valid <= 1'b1;
		item_ch.mode <= mode;
		item_ch.table_select <= sel;
		item_ch.coef_index <= idx;
		item_ch.coef_value <= coef;
		item_ch.audio_in <= sample;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		if (mode == MODE_COEF) begin
			if (sel != STAGE_NONE) coef_tab[sel][idx] = coef;
		end else begin
			predict_audio(sample);
		end
		gap = 0;
		if (!steady_source) begin
			gap = $urandom_range(0, 99);
			gap = (gap < 65) ? 0 : (gap < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		end
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_audio(input logic [SAMPLE_W-1:0] sample);
		send_item(MODE_AUDIO, $urandom(), $urandom(), $urandom(), sample);
	endtask

	task automatic send_coef(input logic [SEL_W-1:0] sel, input logic [CIDX_W-1:0] idx,
			input logic [ACC_W-1:0] coef);
		send_item(MODE_COEF, sel, idx, coef, $urandom());
	endtask

	// waits for every expected result, then lets the block settle
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (pending_pcm.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_TAPS_FIRST, REG_TAPS_SECOND, REG_TAPS_THIRD: taps_reg[idx] = val[TAPS_W-1:0];
			REG_UPSAMPLE_FIRST, REG_UPSAMPLE_SECOND, REG_UPSAMPLE_THIRD: begin
				repeat_reg[idx - REG_UPSAMPLE_FIRST] = val[UP_W-1:0];
			end
			REG_DECIMATION: decim_reg = val;
			default: ;
		endcase
	endtask

	task automatic set_resampler(input int t1, input int t2, input int t3, input int u1,
			input int u2, input int u3, input int dec);
		write_reg(REG_TAPS_FIRST, t1);
		write_reg(REG_TAPS_SECOND, t2);
		write_reg(REG_TAPS_THIRD, t3);
		write_reg(REG_UPSAMPLE_FIRST, u1);
		write_reg(REG_UPSAMPLE_SECOND, u2);
		write_reg(REG_UPSAMPLE_THIRD, u3);
		write_reg(REG_DECIMATION, dec);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [ACC_W-1:0] rand_coef();
		if ($urandom_range(0, 3) == 0) return $urandom();
		return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
	endfunction

	task automatic test_coef_tables();
		send_coef(STAGE_FIRST, 0, 32'h0001_0000);
		send_coef(STAGE_FIRST, 1, 32'h7FFF_FFFF);
		send_coef(STAGE_SECOND, 0, 32'h8000_0000);
		send_coef(STAGE_SECOND, 31, 32'hFFFF_FFFF);
		send_coef(STAGE_THIRD, 0, 32'h0002_0000);
		send_coef(STAGE_THIRD, 31, 32'h0000_8000);
		send_coef(STAGE_NONE, 5, 32'h1234_5678);
		for (int i = 1; i < 4; i++) begin
			send_coef(STAGE_SECOND, i, rand_coef());
			send_coef(STAGE_THIRD, i, rand_coef());
		end
		send_coef(STAGE_SECOND, 1, 32'h0000_C000);
	endtask

	task automatic test_directed_audio();
		send_audio(16'sh7FFF);
		send_audio(16'sh8000);
		send_audio(16'sh0000);
		send_audio(16'shFFFF);
		drain();
		// odd first stage, even second, third with pairs and centre
		set_resampler(3, 4, 5, 2, 2, 3, 2);
		send_audio(16'sh4000);
		send_audio(16'shC123);
		drain();
		// zero lengths, zero repeat (no results) and zero decimation
		set_resampler(0, 0, 0, 0, 1, 1, 0);
		send_audio(16'sh1111);
		drain();
		set_resampler(2, 1, 1, 1, 0, 1, 0);
		send_audio(16'sh2222);
		drain();
		// oversized settings clamp to the largest ring and repeat
		write_reg(REG_UNUSED, 16'hFFFF);
		set_resampler(127, 127, 127, 7, 5, 6, 65535);
		send_audio(16'sh7FFF);
		send_audio(16'sh8001);
		drain();
		set_resampler(64, 64, 64, 4, 4, 4, 1);
		send_audio(16'sh0400);
		drain();
	endtask

	task automatic random_phase(input int count);
		int t[3];
		int u[3];
		int dec;
		for (int k = 0; k < 3; k++) begin
			t[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
			u[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 3);
		end
		dec = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4);
		set_resampler(t[0], t[1], t[2], u[0], u[1], u[2], dec);
		steady_source = ($urandom_range(0, 3) == 0);
		steady_sink = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0)
				send_coef($urandom_range(0, 3), $urandom(), rand_coef());
			else
				send_audio($urandom());
		end
		drain();
		steady_source = 0;
		steady_sink = 0;
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 7; p++) random_phase(60);
	endtask

	task automatic test_backpressure();
		set_resampler(6, 4, 5, 3, 2, 2, 1);
		steady_source = 1;
		hold_request = 600;
		for (int i = 0; i < 20; i++) send_audio($urandom());
		steady_source = 0;
		drain();
	endtask

	// result checker with random stalls
	initial begin
		int stall;
		pcm_result_t want;
		stall = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				if (pending_pcm.size() == 0) begin
					$error("unexpected result audio_out=%0d last=%0b",
						result_ch.audio_out, result_ch.last);
					errors++;
				end else begin
					want = pending_pcm.pop_front();
					pcm_checked++;
					if (result_ch.audio_out !== want.audio_out) begin
						$error("audio_out expected %0d actual %0d",
							want.audio_out, result_ch.audio_out);
						errors++;
					end
					if (result_ch.last !== want.last) begin
						$error("last expected %0b actual %0b", want.last, result_ch.last);
						errors++;
					end
				end
			end
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end
			if (stall > 0) begin
				stall--;
				result_ch.ready <= 1'b0;
			end else if (steady_sink || $urandom_range(0, 99) < 70) begin
				result_ch.ready <= 1'b1;
			end else begin
				stall = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				result_ch.ready <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.mode <= MODE_AUDIO;
		item_ch.table_select <= '0;
		item_ch.coef_index <= '0;
		item_ch.coef_value <= '0;
		item_ch.audio_in <= '0;
		for (int k = 0; k < 3; k++) begin
			taps_reg[k] = 1;
			repeat_reg[k] = 1;
			ring_head[k] = 0;
			for (int i = 0; i < RING_DEPTH; i++) acc_ring[k][i] = '0;
			for (int i = 0; i < TABLE_DEPTH; i++) coef_tab[k][i] = '0;
		end
		decim_reg = 1;
		tick_count = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_coef_tables();
		test_directed_audio();
		test_random_traffic();
		test_backpressure();
		drain();
		$display("covered %0d input items and %0d checked output samples", items_sent,
			pcm_checked);
		$display("across directed, clamped, random and back-pressure resampler settings");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
